/* sv/simple_moving_average_core_assert.svh */
// ----------------------------------------------------------------------------
// simple moving average assertion macros
// property macros shared by the checker of the moving average core
// ----------------------------------------------------------------------------
`ifndef SIMPLE_MOVING_AVERAGE_CORE_ASSERT_SVH
`define SIMPLE_MOVING_AVERAGE_CORE_ASSERT_SVH

// same-cycle implication
`define SMA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sma assertion failed");

// next-cycle implication
`define SMA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sma assertion failed");

`endif

/* sv/sma_pkg.sv */
// ----------------------------------------------------------------------------
// sma_pkg
// shared constants and types of the moving average core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sma_pkg;

    localparam int MAX_WINDOW_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CFG_BITS        = 7;
    localparam int LEN_RESET       = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_DIV
    } t_state;

    typedef struct packed {
        logic clr;
        logic shift;
    } t_cell_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

/* sv/simple_moving_average_core.sv */
// an accepted sample updates the running sum, the divider then divides it by the length,
// and the quotient is loaded into the output register; no sample is taken until that load
// the next sample is taken while a result still waits on the output register
// reset (synchronous, active low) and any length write clear the sample line and sum
// length resets to 8, clamped to the line depth; no clearing pass is needed
// ----------------------------------------------------------------------------
// simple_moving_average_core
// moving average over a chain of sample cells with a running sum and divider
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module simple_moving_average_core #(
    parameter int MAX_WINDOW  = sma_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = sma_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sma_pkg::CFG_BITS-1:0]  i_cfg_wdata,
    input  logic                          i_sample_valid,
    output logic                          o_sample_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_average_valid,
    input  logic                          i_average_ready,
    output logic signed [SAMPLE_BITS-1:0] o_average
);

    localparam int LEN_BITS  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_BITS  = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int RESET_LEN = (sma_pkg::LEN_RESET > MAX_WINDOW) ? MAX_WINDOW
                                                                 : sma_pkg::LEN_RESET;

    sma_pkg::t_state     r_state, n_state;
    logic [LEN_BITS-1:0] r_len, n_len;
    logic signed [SUM_BITS-1:0] r_sum, n_sum;
    logic                r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out;

    logic                accept;
    logic                div_start;
    logic                out_load;
    sma_pkg::t_cell_ctrl cell_ctrl;
    sma_pkg::t_div_stat  div_stat;
    logic signed [SAMPLE_BITS-1:0] quotient;

    logic signed [SAMPLE_BITS-1:0] line [MAX_WINDOW+1];
    logic        [SAMPLE_BITS-1:0] taps [MAX_WINDOW];
    logic        [MAX_WINDOW-1:0]  last;
    logic        [SAMPLE_BITS-1:0] tap_or;

    // length write with clamp
    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_len = LEN_BITS'(1);
        end else if (32'(i_cfg_wdata) > MAX_WINDOW) begin
            n_len = LEN_BITS'(MAX_WINDOW);
        end else begin
            n_len = LEN_BITS'(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_BITS'(RESET_LEN);
        end else if (i_cfg_we) begin
            r_len <= n_len;
        end
    end

    // sample line
    assign cell_ctrl.clr   = i_cfg_we;
    assign cell_ctrl.shift = accept;
    assign line[0]         = i_sample;

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        assign last[g] = (r_len == LEN_BITS'(g + 1));
        sma_cell #(
            .SAMPLE_BITS(SAMPLE_BITS)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctrl (cell_ctrl),
            .i_last (last[g]),
            .i_data (line[g]),
            .o_data (line[g+1]),
            .o_tap  (taps[g])
        );
    end

    always_comb begin
        tap_or = '0;
        for (int k = 0; k < MAX_WINDOW; k++) begin
            tap_or = tap_or | taps[k];
        end
    end

    // running sum
    assign n_sum = r_sum - SUM_BITS'($signed(tap_or)) + SUM_BITS'(i_sample);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_sum <= '0;
        end else if (accept) begin
            r_sum <= n_sum;
        end
    end

    sma_div #(
        .SUM_BITS   (SUM_BITS),
        .LEN_BITS   (LEN_BITS),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(r_sum),
        .i_divisor (r_len),
        .o_stat    (div_stat),
        .o_quotient(quotient)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sma_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_sample_ready = 1'b0;
        div_start      = 1'b0;
        out_load       = 1'b0;
        case (r_state)
            sma_pkg::ST_IDLE: begin
                o_sample_ready = 1'b1;
                if (i_sample_valid) begin
                    n_state = sma_pkg::ST_START;
                end
            end
            sma_pkg::ST_START: begin
                div_start = 1'b1;
                n_state   = sma_pkg::ST_DIV;
            end
            sma_pkg::ST_DIV: begin
                if (div_stat.done && !div_stat.busy && (!r_out_valid || i_average_ready)) begin
                    out_load = 1'b1;
                    n_state  = sma_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sma_pkg::ST_IDLE;
            end
        endcase
    end

    assign accept = i_sample_valid && o_sample_ready;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_average_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= quotient;
        end
    end

    assign o_average_valid = r_out_valid;
    assign o_average       = r_out;

endmodule

/* sv/sma_cell.sv */
// ----------------------------------------------------------------------------
// sma_cell
// one stage of the sample line: holds a sample, takes its neighbour's on a push
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sma_cell #(
    parameter int SAMPLE_BITS = sma_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sma_pkg::t_cell_ctrl           i_ctrl,
    input  logic                          i_last,
    input  logic signed [SAMPLE_BITS-1:0] i_data,
    output logic signed [SAMPLE_BITS-1:0] o_data,
    output logic        [SAMPLE_BITS-1:0] o_tap
);

    logic signed [SAMPLE_BITS-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clr) begin
            r_data <= '0;
        end else if (i_ctrl.shift) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;
    assign o_tap  = i_last ? r_data : '0;

endmodule

/* sv/sma_div.sv */
// ----------------------------------------------------------------------------
// sma_div
// bit-serial restoring divider, signed sum by unsigned length, truncating
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sma_div #(
    parameter int SUM_BITS    = 22,
    parameter int LEN_BITS    = 7,
    parameter int SAMPLE_BITS = sma_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [SUM_BITS-1:0]    i_dividend,
    input  logic        [LEN_BITS-1:0]    i_divisor,
    output sma_pkg::t_div_stat            o_stat,
    output logic signed [SAMPLE_BITS-1:0] o_quotient
);

    localparam int CNT_BITS = $clog2(SUM_BITS + 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_neg;
    logic [LEN_BITS-1:0] r_rem;
    logic [SUM_BITS-1:0] r_quo;
    logic [LEN_BITS-1:0] r_dsor;

    logic [LEN_BITS-1:0] n_rem;
    logic [SUM_BITS-1:0] n_quo;
    logic [LEN_BITS:0]   rem_sh;
    logic [LEN_BITS:0]   trial;
    logic [SUM_BITS-1:0] mag;
    logic [SUM_BITS-1:0] quo_signed;

    assign mag = i_dividend[SUM_BITS-1] ? (~i_dividend + 1'b1) : i_dividend;

    always_comb begin
        rem_sh = {r_rem, r_quo[SUM_BITS-1]};
        trial  = rem_sh - {1'b0, r_dsor};
        if (rem_sh >= {1'b0, r_dsor}) begin
            n_rem = trial[LEN_BITS-1:0];
            n_quo = {r_quo[SUM_BITS-2:0], 1'b1};
        end else begin
            n_rem = rem_sh[LEN_BITS-1:0];
            n_quo = {r_quo[SUM_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_BITS'(SUM_BITS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_BITS'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg  <= i_dividend[SUM_BITS-1];
            r_rem  <= '0;
            r_quo  <= mag;
            r_dsor <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign quo_signed  = r_neg ? (~r_quo + 1'b1) : r_quo;
    assign o_quotient  = quo_signed[SAMPLE_BITS-1:0];
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

/* sv/sma_checker.sv */
// ----------------------------------------------------------------------------
// sma_checker
// port-level checks of the moving average core, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "simple_moving_average_core_assert.svh"

module sma_checker #(
    parameter int SAMPLE_BITS = sma_pkg::SAMPLE_BITS_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_sample_valid,
    input logic                          o_sample_ready,
    input logic                          o_average_valid,
    input logic                          i_average_ready,
    input logic signed [SAMPLE_BITS-1:0] o_average
);

    // result beat held while stalled
    `SMA_ASSERT_NEXT(a_out_hold, o_average_valid && !i_average_ready, o_average_valid)
    `SMA_ASSERT_NEXT(a_out_stable, o_average_valid && !i_average_ready, $stable(o_average))

    // one sample in flight at a time
    `SMA_ASSERT_NEXT(a_one_in_flight, i_sample_valid && o_sample_ready, !o_sample_ready)

    // a new result comes with the input side reopening
    `SMA_ASSERT_NOW(a_result_frees_input, $rose(o_average_valid), o_sample_ready)

endmodule

bind simple_moving_average_core sma_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_sma_checker (.*);

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// moving average core bench: drives sample beats in bursts against a stalling
// receiver, tracks the window and running sum in a scoreboard class and checks
// every average beat in order, across several window lengths and their limits
// ----------------------------------------------------------------------------

class average_tracker;
    localparam int DEPTH = sma_pkg::MAX_WINDOW_DEF;

    shortint ring [DEPTH];
    longint  sum;
    int      head;
    int      len;
    shortint expected_avgs [$];
    int      errors;

    function new();
        errors = 0;
        set_length(sma_pkg::LEN_RESET);
    endfunction

    // a length write also empties the window
    function void set_length(int unsigned value);
        int unsigned v;
        v = value & 32'h7f;
        if (v < 1) begin
            len = 1;
        end else if (v > DEPTH) begin
            len = DEPTH;
        end else begin
            len = v;
        end
        foreach (ring[i]) ring[i] = 0;
        sum  = 0;
        head = 0;
    endfunction

    function void take_sample(logic signed [15:0] s);
        int old_pos;
        old_pos = (head + DEPTH - len) % DEPTH;
        sum = sum - ring[old_pos] + s;
        ring[head] = s;
        head = (head + 1) % DEPTH;
        expected_avgs.push_back(shortint'(sum / len));
    endfunction

    function void check_average(logic signed [15:0] got);
        shortint want;
        if (expected_avgs.size() == 0) begin
            errors++;
            $display("%0t: unexpected average beat, got %0d", $time, got);
            return;
        end
        want = expected_avgs.pop_front();
        if (got !== want) begin
            errors++;
            $display("%0t: average expected %0d got %0d", $time, want, got);
        end
    endfunction

    function int pending();
        return expected_avgs.size();
    endfunction
endclass

module tb;

    localparam int SW          = sma_pkg::SAMPLE_BITS_DEF;
    localparam int SETTLE      = 40;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_ITEMS = 68;

    logic                         i_clk           = 1'b0;
    logic                         i_rst_n         = 1'b0;
    logic                         i_cfg_we        = 1'b0;
    logic [sma_pkg::CFG_BITS-1:0] i_cfg_wdata     = '0;
    logic                         i_sample_valid  = 1'b0;
    logic signed [SW-1:0]         i_sample        = '0;
    logic                         i_average_ready = 1'b0;
    logic                         o_sample_ready;
    logic                         o_average_valid;
    logic signed [SW-1:0]         o_average;

    average_tracker board = new();
    bit             hold_req = 1'b0;
    int             cycle_count = 0;

    simple_moving_average_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_sample_valid  (i_sample_valid),
        .o_sample_ready  (o_sample_ready),
        .i_sample        (i_sample),
        .o_average_valid (o_average_valid),
        .i_average_ready (i_average_ready),
        .o_average       (o_average)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_average_valid && i_average_ready) begin
            board.check_average(o_average);
        end
    end

    function automatic logic signed [SW-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2, 3:    return SW'($signed($urandom_range(0, 200)) - 100);
            default: return SW'($urandom);
        endcase
    endfunction

    task automatic send_sample(input logic signed [SW-1:0] s);
        i_sample_valid <= 1'b1;
        i_sample       <= s;
        do @(posedge i_clk); while (!o_sample_ready);
        board.take_sample(s);
        @(negedge i_clk);
    endtask

    task automatic drain();
        while (board.pending() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_length(input int unsigned value);
        i_sample_valid <= 1'b0;
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value[sma_pkg::CFG_BITS-1:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        board.set_length(value);
    endtask

    task automatic run_phase(input int unsigned length, input int items, input bit hold);
        int burst;
        int gap;
        write_length(length);
        if (hold) begin
            hold_req = 1'b1;
        end
        burst = 0;
        for (int n = 0; n < items; n++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 40);
                gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0) begin
                    i_sample_valid <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            send_sample(pick_sample());
            burst--;
        end
    endtask

    // receiver: always ready, random, mostly stalled, or held stalled
    initial begin
        int mode;
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                i_average_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                mode = $urandom_range(0, 2);
                repeat (64) begin
                    case (mode)
                        0:       i_average_ready <= 1'b1;
                        1:       i_average_ready <= 1'($urandom_range(0, 1));
                        default: i_average_ready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(negedge i_clk);
                end
            end
        end
    end

    initial begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset length of 8, zeros still in the window
        send_sample(16'sh7fff);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'sh0001);
        send_sample(-16'sd1);
        send_sample(16'sh0000);
        send_sample(-16'sd7);
        send_sample(16'sh5555);
        send_sample(16'shaaaa);

        // zero length acts as one
        write_length(0);
        send_sample(16'sh7fff);
        send_sample(-16'sd5);

        // full depth, then a length above the depth, then length one
        write_length(64);
        repeat (3) send_sample(16'sh7fff);
        repeat (3) send_sample(16'sh8000);
        write_length(127);
        send_sample(16'sh8000);
        send_sample(-16'sd63);
        write_length(1);
        send_sample(16'sh8000);
        send_sample(-16'sd3);

        run_phase(64, PHASE_ITEMS, 1'b0);
        run_phase(1, PHASE_ITEMS, 1'b1);
        run_phase(127, PHASE_ITEMS, 1'b0);
        run_phase(0, PHASE_ITEMS, 1'b0);
        run_phase(2, PHASE_ITEMS, 1'b0);
        run_phase(3, PHASE_ITEMS, 1'b1);
        run_phase(63, PHASE_ITEMS, 1'b0);
        run_phase($urandom_range(65, 126), PHASE_ITEMS, 1'b0);
        for (int p = 0; p < 2; p++) begin
            run_phase($urandom_range(4, 62), PHASE_ITEMS, 1'b0);
        end

        i_sample_valid <= 1'b0;
        drain();
        if (board.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
